// File: rtl/core/mbbp_pkg.sv
// shared types and constants for the monochrome bitmap byte packer
// no dependencies

package mbbp_pkg;

    // default geometry limits, handed down from the top level
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    // geometry arithmetic width, enough for limits up to 4096 plus one
    localparam int GEO_W   = 13;
    // column index width carried through the queue, enough for 4096 columns
    localparam int COL_BITS = 12;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 2'd2;

    localparam logic [CFG_DATA_W-1:0] RST_WIDTH  = 11'd128;
    localparam logic [CFG_DATA_W-1:0] RST_HEIGHT = 11'd64;

    // floor(sum/3) > 127 is the same as sum >= 3*128
    localparam logic [9:0] ON_SUM = 10'(3 * 128);

    // minimum active geometry
    localparam logic [GEO_W-1:0] MIN_WIDTH  = GEO_W'(2);
    localparam logic [GEO_W-1:0] MIN_HEIGHT = GEO_W'(8);

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        OP_HORZ,
        OP_VERT_ACC,
        OP_VERT_EMIT
    } t_op;

    typedef struct packed {
        t_op                 op;
        logic [7:0]          data;  // finished byte, or pixel bit in bit 0
        logic [2:0]          sub;   // row within the band
        logic [COL_BITS-1:0] col;
    } t_item;

    typedef struct packed {
        logic clr_busy;
    } t_back_status;

endpackage

// File: rtl/core/mbbp_if.sv
// handshake channel interfaces for pixels, packed bytes and register writes
// depends on mbbp_pkg

interface mbbp_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    modport source (output valid, red, green, blue, input ready);
    modport sink   (input valid, red, green, blue, output ready);
endinterface

interface mbbp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] packed_byte;
    modport source (output valid, packed_byte, input ready);
    modport sink   (input valid, packed_byte, output ready);
endinterface

interface mbbp_cfg_if
    import mbbp_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/mbbp_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies

module mbbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/mbbp_front.sv
// front end: config registers, pixel threshold, frame counters, horizontal runs
// depends on mbbp_pkg and mbbp_if

module mbbp_front
    import mbbp_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mbbp_pix_if.sink     i_pix,
    mbbp_cfg_if.sink     i_cfg,
    input  logic         i_q_full,
    input  t_back_status i_back,
    output logic         o_push,
    output t_item        o_item
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    logic                  r_mode;
    logic [CFG_DATA_W-1:0] r_width;
    logic [CFG_DATA_W-1:0] r_height;
    logic [CW-1:0]         r_col,  n_col;
    logic [RW-1:0]         r_row,  n_row;
    logic [7:0]            r_run,  n_run;
    logic [2:0]            r_pos,  n_pos;

    logic [9:0]       sum;
    logic             on;
    logic [GEO_W-1:0] w_eff, h_eff, w_ext, h_ext, col_next, row_next, band_end;
    logic             last_col, last_row, active, accept, full_band;
    logic [7:0]       run_or;

    assign i_cfg.ready = 1'b1;
    assign i_pix.ready = !i_q_full && !i_back.clr_busy;
    assign accept      = i_pix.valid && i_pix.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= 1'b0;
            r_width  <= RST_WIDTH;
            r_height <= RST_HEIGHT;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_DIRECTION: r_mode   <= i_cfg.data[0];
                REG_WIDTH:     r_width  <= i_cfg.data;
                REG_HEIGHT:    r_height <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // clamp geometry to the store limits
    assign w_ext = GEO_W'(r_width);
    assign h_ext = GEO_W'(r_height);
    assign w_eff = (w_ext > GEO_W'(MAX_WIDTH))  ? GEO_W'(MAX_WIDTH)  : w_ext;
    assign h_eff = (h_ext > GEO_W'(MAX_HEIGHT)) ? GEO_W'(MAX_HEIGHT) : h_ext;

    assign sum = 10'(i_pix.red) + 10'(i_pix.green) + 10'(i_pix.blue);
    assign on  = (sum >= ON_SUM);

    assign col_next  = GEO_W'(r_col) + GEO_W'(1);
    assign row_next  = GEO_W'(r_row) + GEO_W'(1);
    assign band_end  = GEO_W'(r_row) | GEO_W'(7);
    assign last_col  = (col_next >= w_eff);
    assign last_row  = (row_next >= h_eff);
    assign full_band = (band_end < h_eff);
    assign active    = (w_eff >= MIN_WIDTH) && (h_eff >= MIN_HEIGHT);
    assign run_or    = r_run | (8'(on) << r_pos);

    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_run  = r_run;
        n_pos  = r_pos;
        o_push = 1'b0;
        o_item.op   = OP_HORZ;
        o_item.data = run_or;
        o_item.sub  = r_row[2:0];
        o_item.col  = COL_BITS'(r_col);

        if (accept) begin
            if (!active) begin
                n_run = '0;
                n_pos = '0;
            end else if (!r_mode) begin
                if (r_pos == 3'd7) begin
                    o_push = 1'b1;
                    n_run  = '0;
                    n_pos  = '0;
                end else begin
                    n_run = run_or;
                    n_pos = r_pos + 3'd1;
                end
            end else begin
                n_run       = '0;
                n_pos       = '0;
                o_push      = 1'b1;
                o_item.data = 8'(on);
                o_item.op   = (r_row[2:0] == 3'd7 && full_band) ? OP_VERT_EMIT
                                                                 : OP_VERT_ACC;
            end

            if (last_col && last_row) begin
                n_col = '0;
                n_row = '0;
                n_run = '0;
                n_pos = '0;
            end else if (last_col) begin
                n_col = '0;
                n_row = r_row + RW'(1);
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_run <= '0;
            r_pos <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            r_run <= n_run;
            r_pos <= n_pos;
        end
    end

endmodule

// File: rtl/core/mbbp_queue.sv
// short fifo of classified items between front and back
// depends on mbbp_pkg

module mbbp_queue
    import mbbp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_valid,
    output t_item o_item
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    t_item                r_mem [QUEUE_DEPTH];
    logic [PW-1:0]        r_wr_ptr;
    logic [PW-1:0]        r_rd_ptr;
    logic [PW:0]          r_count;
    logic                 do_push, do_pop;

    assign o_full  = (r_count == (PW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(QUEUE_DEPTH-1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(QUEUE_DEPTH-1)) ? '0 : r_rd_ptr + PW'(1);
            end
            r_count <= r_count + (PW+1)'(do_push) - (PW+1)'(do_pop);
        end
    end

endmodule

// File: rtl/core/mbbp_back.sv
// back end: column store read-modify-write, store clearing pass, output register
// depends on mbbp_pkg, mbbp_if and mbbp_ram

module mbbp_back
    import mbbp_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_q_valid,
    input  t_item        i_q_item,
    output logic         o_q_pop,
    output t_back_status o_status,
    mbbp_byte_if.source  o_byte
);

    localparam int CW = $clog2(MAX_WIDTH);

    logic          r_clr_busy;
    logic [CW-1:0] r_clr_addr;
    logic          r_s1_valid;
    t_item         r_s1_item;
    logic          r_out_valid, n_out_valid;
    logic [7:0]    r_out_byte;

    logic          out_free, s1_emits, s1_fire, s1_load, is_vert;
    logic [7:0]    rdata, cur;
    logic          we;
    logic [CW-1:0] waddr;
    logic [7:0]    wdata;

    assign o_status.clr_busy = r_clr_busy;

    assign out_free = !r_out_valid || o_byte.ready;
    assign s1_emits = (r_s1_item.op != OP_VERT_ACC);
    assign s1_fire  = r_s1_valid && (!s1_emits || out_free);
    assign s1_load  = i_q_valid && !r_clr_busy && (!r_s1_valid || s1_fire);
    assign o_q_pop  = s1_load;

    mbbp_ram #(
        .WIDTH (8),
        .DEPTH (MAX_WIDTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (s1_load),
        .i_raddr (i_q_item.col[CW-1:0]),
        .o_rdata (rdata)
    );

    // band's first row starts from zero, later rows merge into the stored byte
    always_comb begin
        is_vert = 1'b0;
        cur     = 8'(r_s1_item.data[0]) << r_s1_item.sub;
        case (r_s1_item.op)
            OP_HORZ: begin
                cur = r_s1_item.data;
            end
            OP_VERT_ACC, OP_VERT_EMIT: begin
                is_vert = 1'b1;
                if (r_s1_item.sub != 3'd0) begin
                    cur = rdata | (8'(r_s1_item.data[0]) << r_s1_item.sub);
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        if (r_clr_busy) begin
            we    = 1'b1;
            waddr = r_clr_addr;
            wdata = '0;
        end else begin
            we    = s1_fire && is_vert;
            waddr = r_s1_item.col[CW-1:0];
            wdata = (r_s1_item.op == OP_VERT_EMIT) ? 8'd0 : cur;
        end
    end

    assign n_out_valid = (r_out_valid && !o_byte.ready) || (s1_fire && s1_emits);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy  <= 1'b1;
            r_clr_addr  <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + CW'(1);
                if (r_clr_addr == CW'(MAX_WIDTH-1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (s1_load) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_s1_item <= i_q_item;
        end
        if (s1_fire && s1_emits) begin
            r_out_byte <= cur;
        end
    end

    assign o_byte.valid       = r_out_valid;
    assign o_byte.packed_byte = r_out_byte;

endmodule

// File: rtl/core/mono_bitmap_byte_packer.sv
// top level of the monochrome bitmap byte packer: pixels in, packed bytes out
// path: a completed byte goes through the queue, stage 1 and the output register
// throughput: one pixel per clock unless stalled, limited by the single store read-modify-write
// reset: synchronous; afterwards the column store is swept to zero, and during
// the sweep pixels are held off, register writes are taken throughout
// depends on mbbp_pkg, mbbp_if, mbbp_front, mbbp_queue, mbbp_back, mbbp_ram

module mono_bitmap_byte_packer
    import mbbp_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mbbp_pix_if.sink    i_pix,
    mbbp_cfg_if.sink    i_cfg,
    mbbp_byte_if.source o_byte
);

    // front to queue
    logic         push;
    t_item        push_item;
    // queue to back
    logic         q_full;
    logic         q_valid;
    logic         q_pop;
    t_item        q_item;
    // back status, holds pixels off while the store is being cleared
    t_back_status back_status;

    // front end: thresholds each pixel, steps the frame counters and
    // assembles horizontal runs; only transactions that touch the store or
    // finish a byte are queued
    mbbp_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_pix    (i_pix),
        .i_cfg    (i_cfg),
        .i_q_full (q_full),
        .i_back   (back_status),
        .o_push   (push),
        .o_item   (push_item)
    );

    // decouples the front from output stalls
    mbbp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    // back end: reads the column byte as an item is loaded, merges the pixel
    // bit and writes it back as the item leaves; consecutive items always hit
    // different columns, so no forwarding is needed
    mbbp_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_q_pop   (q_pop),
        .o_status  (back_status),
        .o_byte    (o_byte)
    );

endmodule

// File: rtl/core/mbbp_checker.sv
// port-level checks for the monochrome bitmap byte packer, bound to the top level
// depends on mono_bitmap_byte_packer

module mbbp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_pix_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte
);

    // the store clearing pass holds pixels off right after reset
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_pix_ready)
        else $error("pixel input ready right after reset");

    // no result byte comes out of reset
    a_no_out_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    // a stalled result byte holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_byte))
        else $error("stalled output transaction changed");

endmodule

bind mono_bitmap_byte_packer mbbp_checker u_mbbp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_pix_ready (i_pix.ready),
    .i_out_valid (o_byte.valid),
    .i_out_ready (o_byte.ready),
    .i_out_byte  (o_byte.packed_byte)
);
